>>> rtl/core/ptga_pkg.sv
// ----------------------------------------------------------------------------
// ptga_pkg
// Shared types, widths and the arctangent table for the pan/tilt gaze block.
// ----------------------------------------------------------------------------
package ptga_pkg;

  // field widths
  localparam int unsigned CoordW  = 21;
  localparam int unsigned NeckW   = 20;
  localparam int unsigned EyeW    = 16;
  localparam int unsigned AngOutW = 17;
  localparam int unsigned HW      = CoordW + 2;   // neck height minus z
  localparam int unsigned CfgDW   = 20;
  localparam int unsigned CfgIW   = 2;

  // square root: root bits, radicand bits, partial remainder bits
  localparam int unsigned SqN    = 30;
  localparam int unsigned RadW   = 2 * SqN;
  localparam int unsigned RemW   = SqN + 4;

  // cordic: vector width, angle width (1/65536 degree), stage count
  localparam int unsigned CordW  = 34;
  localparam int unsigned AngW   = 26;
  localparam int unsigned CordN  = 16;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned Lanes  = 3;

  localparam logic signed [AngW-1:0] Ang90 = AngW'(5898240);

  // register indexes
  typedef enum logic [CfgIW-1:0] {
    REG_NECK_HEIGHT = 2'd0,
    REG_EYE_OFFSET  = 2'd1,
    REG_TILT_FLOOR  = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_e;

  // lane order in the cordic chain
  localparam int unsigned LanePan   = 0;
  localparam int unsigned LaneAlpha = 1;
  localparam int unsigned LaneBeta  = 2;

  // values that ride along the square root chain
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [HW-1:0]     h;
    logic [EyeW-1:0]          e;
    logic                     close;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [SqN-1:0]  root;
    logic [RadW-1:0] rad;
  } sq_lane_t;

  typedef struct packed {
    sq_lane_t r;
    sq_lane_t s;
    side_t    side;
  } sq_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cd_lane_t;

  // special cases carried to the output stage
  typedef struct packed {
    logic pan_zero;
    logic alpha_zero;
    logic close;
    logic eye_zero;
  } cd_flags_t;

  typedef struct packed {
    cd_lane_t [Lanes-1:0] lane;
    cd_flags_t            flags;
  } cd_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [AngW-1:0] atan_step(input logic [IdxW-1:0] i);
    logic signed [AngW-1:0] a;
    a = '0;
    case (i)
      5'd0:  a = AngW'(2949120);
      5'd1:  a = AngW'(1740967);
      5'd2:  a = AngW'(919879);
      5'd3:  a = AngW'(466945);
      5'd4:  a = AngW'(234379);
      5'd5:  a = AngW'(117304);
      5'd6:  a = AngW'(58666);
      5'd7:  a = AngW'(29335);
      5'd8:  a = AngW'(14668);
      5'd9:  a = AngW'(7334);
      5'd10: a = AngW'(3667);
      5'd11: a = AngW'(1833);
      5'd12: a = AngW'(917);
      5'd13: a = AngW'(458);
      5'd14: a = AngW'(229);
      5'd15: a = AngW'(115);
      5'd16: a = AngW'(57);
      5'd17: a = AngW'(29);
      5'd18: a = AngW'(14);
      5'd19: a = AngW'(7);
      5'd20: a = AngW'(4);
      5'd21: a = AngW'(2);
      5'd22: a = AngW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/ptga_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ptga_sqrt_cell
// One bit of two restoring square roots, registered, with the sideband.
// ----------------------------------------------------------------------------
module ptga_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ptga_pkg::sq_t   data_i,
  output logic            valid_o,
  output ptga_pkg::sq_t   data_o
);
  import ptga_pkg::*;

  logic  valid_q;
  sq_t   data_d, data_q;

  function automatic sq_lane_t sq_bit(input sq_lane_t l);
    sq_lane_t        o;
    logic [RemW-1:0] rem_n;
    logic [RemW-1:0] trial;
    rem_n = {l.rem[RemW-3:0], l.rad[RadW-1 -: 2]};
    trial = {2'b00, l.root, 2'b01};
    o.rad = {l.rad[RadW-3:0], 2'b00};
    if (rem_n >= trial) begin
      o.rem  = rem_n - trial;
      o.root = {l.root[SqN-2:0], 1'b1};
    end else begin
      o.rem  = rem_n;
      o.root = {l.root[SqN-2:0], 1'b0};
    end
    return o;
  endfunction

  // one root bit for each lane
  always_comb begin
    data_d.r    = sq_bit(data_i.r);
    data_d.s    = sq_bit(data_i.s);
    data_d.side = data_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/ptga_cordic_cell.sv
// ----------------------------------------------------------------------------
// ptga_cordic_cell
// One vectoring micro-rotation for three lanes, registered.
// ----------------------------------------------------------------------------
module ptga_cordic_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [ptga_pkg::IdxW-1:0]       idx_i,
  input  logic                            valid_i,
  input  ptga_pkg::cd_t                   data_i,
  output logic                            valid_o,
  output ptga_pkg::cd_t                   data_o
);
  import ptga_pkg::*;

  logic valid_q;
  cd_t  data_d, data_q;

  // rotate each lane toward the x axis
  always_comb begin
    logic signed [CordW-1:0] xs, ys;
    logic signed [AngW-1:0]  a;
    data_d = data_i;
    a = atan_step(idx_i);
    for (int k = 0; k < Lanes; k++) begin
      xs = data_i.lane[k].x >>> idx_i;
      ys = data_i.lane[k].y >>> idx_i;
      if (data_i.lane[k].y > 0) begin
        data_d.lane[k].x = data_i.lane[k].x + ys;
        data_d.lane[k].y = data_i.lane[k].y - xs;
        data_d.lane[k].z = data_i.lane[k].z + a;
      end else begin
        data_d.lane[k].x = data_i.lane[k].x - ys;
        data_d.lane[k].y = data_i.lane[k].y + xs;
        data_d.lane[k].z = data_i.lane[k].z - a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/pan_tilt_gaze_angles.sv
// ----------------------------------------------------------------------------
// pan_tilt_gaze_angles
// Pan and tilt angles that aim a camera head at one target point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one target item (x, y, z in 1/16 mm, signed 21 bits each).
//   m_axis returns one result item per target: pan and tilt in 1/256 degree
//   in tdata, the clamp and too-close flags in tuser.
//   cfg_* writes neck height (index 0), eye offset (1) and tilt floor (2);
//   other indexes are ignored. Write only while the block is idle.
// Pipeline:
//   from accept to result: capture, squares and sums in registers, a chain
//   of 30 square root cells (one root bit each), one pre-rotation stage,
//   16 cordic cells (one micro-rotation each) and the output register.
//   One item is accepted every cycle while the chain is not stalled.
// Reset:
//   all stages empty, registers back to neck 28251, eye 1184, floor -12032.
// Stall:
//   while a result waits and m_axis_tready is low, the whole chain holds and
//   s_axis_tready drops; a result already shown stays until taken.
// ----------------------------------------------------------------------------
module pan_tilt_gaze_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  // x [20:0], y [41:21], z [62:42]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pan_angle [16:0], tilt_angle [33:17]
  output logic [39:0] m_axis_tdata,
  // tilt_clamped [0], too_close [1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ptga_pkg::CfgIW-1:0] cfg_index,
  input  logic [ptga_pkg::CfgDW-1:0] cfg_data
);
  import ptga_pkg::*;

  localparam logic signed [AngW:0]  Ang180    = (AngW+1)'(11796480);
  localparam logic signed [17:0]    PanLimit  = 18'sd46080;
  localparam logic signed [18:0]    TiltLow   = -19'sd46080;
  localparam logic signed [18:0]    TiltHigh  = 19'sd23040;

  logic en;

  // configuration registers
  logic [NeckW-1:0]          neck_q;
  logic [EyeW-1:0]           eye_q;
  logic signed [AngOutW-1:0] floor_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neck_q  <= NeckW'(28251);
      eye_q   <= EyeW'(1184);
      floor_q <= -17'sd12032;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_NECK_HEIGHT: neck_q  <= cfg_data[NeckW-1:0];
        REG_EYE_OFFSET:  eye_q   <= cfg_data[EyeW-1:0];
        REG_TILT_FLOOR:  floor_q <= $signed(cfg_data[AngOutW-1:0]);
        default: ;
      endcase
    end
  end

  // stage a: capture point, height below neck
  logic                     a_valid_q;
  logic signed [CoordW-1:0] a_x_q, a_y_q;
  logic signed [HW-1:0]     a_h_q;
  logic [EyeW-1:0]          a_e_q;
  logic signed [CoordW-1:0] in_z;

  assign in_z = $signed(s_axis_tdata[62:42]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q <= $signed(s_axis_tdata[20:0]);
      a_y_q <= $signed(s_axis_tdata[41:21]);
      a_h_q <= $signed({3'b000, neck_q}) - $signed({{2{in_z[CoordW-1]}}, in_z});
      a_e_q <= eye_q;
    end
  end

  // stage b: squares
  logic                     b_valid_q;
  logic signed [2*CoordW-1:0] b_xx_q, b_yy_q;
  logic signed [2*HW-1:0]     b_hh_q;
  logic [2*EyeW-1:0]          b_ee_q;
  side_t                      b_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_xx_q         <= a_x_q * a_x_q;
      b_yy_q         <= a_y_q * a_y_q;
      b_hh_q         <= a_h_q * a_h_q;
      b_ee_q         <= a_e_q * a_e_q;
      b_side_q.x     <= a_x_q;
      b_side_q.y     <= a_y_q;
      b_side_q.h     <= a_h_q;
      b_side_q.e     <= a_e_q;
      b_side_q.close <= 1'b0;
    end
  end

  // stage c: floor and neck distances squared, radicands
  logic [2*CoordW-1:0] r2;
  logic [43:0]         d2, diff;
  sq_t                 c_d;
  logic                c_valid_q;
  sq_t                 c_q;

  always_comb begin
    r2   = b_xx_q[2*CoordW-1:0] + b_yy_q[2*CoordW-1:0];
    d2   = 44'(r2) + 44'(b_hh_q[43:0]);
    diff = d2 - 44'(b_ee_q);
    c_d            = '0;
    c_d.side       = b_side_q;
    c_d.side.close = d2 < 44'(b_ee_q);
    c_d.r.rad      = {2'b00, r2, 16'h0000};
    c_d.s.rad      = {diff, 16'h0000};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // square root chain
  logic [SqN:0] sq_valid;
  sq_t          sq_data [SqN+1];

  assign sq_valid[0] = c_valid_q;
  assign sq_data[0]  = c_q;

  for (genvar i = 0; i < SqN; i++) begin : g_sq
    ptga_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // pre-rotation by +-90 degrees into the right half plane
  function automatic cd_lane_t prerot(input logic signed [CordW-1:0] x,
                                      input logic signed [CordW-1:0] y);
    cd_lane_t o;
    o.x = x;
    o.y = y;
    o.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y;
        o.y = -x;
        o.z = Ang90;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -Ang90;
      end
    end
    return o;
  endfunction

  sq_t                     sq_last;
  logic signed [CordW-1:0] px, py, ax, ay, bx, by;
  cd_t                     p_d, p_q;
  logic                    p_valid_q;

  assign sq_last = sq_data[SqN];

  always_comb begin
    px = {{5{sq_last.side.x[CoordW-1]}}, sq_last.side.x, 8'h00};
    py = {{5{sq_last.side.y[CoordW-1]}}, sq_last.side.y, 8'h00};
    ax = {{3{sq_last.side.h[HW-1]}}, sq_last.side.h, 8'h00};
    ay = {4'h0, sq_last.r.root};
    bx = {10'h000, sq_last.side.e, 8'h00};
    by = {4'h0, sq_last.s.root};
    p_d.lane[LanePan]       = prerot(px, py);
    p_d.lane[LaneAlpha]     = prerot(ax, ay);
    p_d.lane[LaneBeta]      = prerot(bx, by);
    p_d.flags.pan_zero      = (px == '0) && (py == '0);
    p_d.flags.alpha_zero    = (ax == '0) && (ay == '0);
    p_d.flags.close         = sq_last.side.close;
    p_d.flags.eye_zero      = sq_last.side.e == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= sq_valid[SqN];
    end
  end

  // cordic chain
  logic [CordN:0] cd_valid;
  cd_t            cd_data [CordN+1];

  assign cd_valid[0] = p_valid_q;
  assign cd_data[0]  = p_q;

  for (genvar i = 0; i < CordN; i++) begin : g_cd
    ptga_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (IdxW'(i)),
      .valid_i (cd_valid[i]),
      .data_i  (cd_data[i]),
      .valid_o (cd_valid[i+1]),
      .data_o  (cd_data[i+1])
    );
  end

  // output stage: rounding, limits, floor clamp
  cd_t                      cd_last;
  logic signed [AngW-1:0]   pan_f, alpha_f, beta_f, pan_r;
  logic signed [AngW:0]     tilt_f, tilt_r;
  logic signed [17:0]       pan_v;
  logic signed [18:0]       tilt_v, floor_x;
  logic [AngOutW-1:0]       pan_o_d, tilt_o_d;
  logic                     clamped_d;

  assign cd_last = cd_data[CordN];

  always_comb begin
    pan_f   = cd_last.flags.pan_zero ? '0 : cd_last.lane[LanePan].z;
    alpha_f = cd_last.flags.alpha_zero ? '0 : cd_last.lane[LaneAlpha].z;
    if (cd_last.flags.close) begin
      beta_f = '0;
    end else if (cd_last.flags.eye_zero) begin
      beta_f = Ang90;
    end else begin
      beta_f = cd_last.lane[LaneBeta].z;
    end
    pan_r = pan_f + AngW'(128);
    pan_v = pan_r[AngW-1:8];
    if (pan_v < -PanLimit) pan_v = -PanLimit;
    if (pan_v > PanLimit)  pan_v = PanLimit;
    pan_o_d = pan_v[AngOutW-1:0];

    tilt_f = (AngW+1)'(alpha_f) + (AngW+1)'(beta_f) - Ang180;
    tilt_r = tilt_f + (AngW+1)'(128);
    tilt_v = tilt_r[AngW:8];
    if (tilt_v < TiltLow)  tilt_v = TiltLow;
    if (tilt_v > TiltHigh) tilt_v = TiltHigh;
    floor_x   = 19'(floor_q);
    clamped_d = tilt_v < floor_x;
    tilt_o_d  = clamped_d ? floor_q : tilt_v[AngOutW-1:0];
  end

  logic                out_valid_q;
  logic [AngOutW-1:0]  pan_q, tilt_q;
  logic                clamped_q, close_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pan_q     <= pan_o_d;
      tilt_q    <= tilt_o_d;
      clamped_q <= clamped_d;
      close_q   <= cd_last.flags.close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cd_valid[CordN];
    end
  end

  // the chain moves whenever the output register is free or being taken
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'h00, tilt_q, pan_q};
  assign m_axis_tuser  = {close_q, clamped_q};

  // checks
  a_clamp_is_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> $signed(m_axis_tdata[33:17]) == floor_q)
    else $error("clamped tilt differs from floor");

  a_tilt_above_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> $signed(m_axis_tdata[33:17]) >= floor_q)
    else $error("unclamped tilt below floor");

  a_pan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[16:0]) >= -17'sd46080) &&
                      ($signed(m_axis_tdata[16:0]) <= 17'sd46080))
    else $error("pan out of range");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c_valid_q) && $stable(p_valid_q))
    else $error("chain moved during stall");

endmodule

>>> tb/pan_tilt_gaze_angles_tb.sv
// ----------------------------------------------------------------------------
// pan_tilt_gaze_angles_tb
// Self-checking bench for the pan/tilt gaze angle block: target items are
// driven on the input stream, every result item is compared field by field
// with a bit-accurate angle predictor, under random idling on both streams
// and several register settings, extremes included.
// ----------------------------------------------------------------------------
module pan_tilt_gaze_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptga_pkg::*;

  localparam int unsigned Stages    = 16;
  localparam longint      Ang180    = 64'sd11796480;
  localparam longint      PanLimit  = 64'sd46080;
  localparam longint      TiltLow   = -64'sd46080;
  localparam longint      TiltHigh  = 64'sd23040;
  localparam int unsigned DrainWait = 80;
  localparam longint      CycleCap  = 64'd600000;

  typedef struct packed {
    logic signed [16:0] pan;
    logic signed [16:0] tilt;
    logic               clamped;
    logic               close;
  } gaze_t;

  typedef struct {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic signed [20:0] z;
    bit                 known;
    gaze_t              want;
  } aim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIW-1:0] cfg_index;
  logic [CfgDW-1:0] cfg_data;

  // predictor copy of the registers
  longint neck_q;
  longint eye_q;
  longint floor_q;

  gaze_t  gaze_q[$];
  int     err_cnt;
  longint cyc_cnt;
  bit     out_busy;   // long stretch without receiver stalls

  pan_tilt_gaze_angles u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  initial begin
    cyc_cnt = 0;
    forever begin
      @(posedge clk_i);
      cyc_cnt++;
      if (cyc_cnt > CycleCap) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // arithmetic shift right that rounds toward minus infinity
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan_step(input int i);
    longint tab[24];
    tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // vectoring rotation, angle in 1/65536 degree
  function automatic longint vec_angle(input longint y, input longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;  y = -t; z = 5898240;
      end else begin
        x = -y; y = t;  z = -5898240;
      end
    end
    for (int i = 0; i < Stages; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_step(i);
      end else begin
        x -= ys; y += xs; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint to_deg256(input longint fine, input longint lo, input longint hi);
    longint v;
    v = asr(fine + 128, 8);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic gaze_t aim_angles(input logic signed [20:0] tx,
                                       input logic signed [20:0] ty,
                                       input logic signed [20:0] tz);
    longint x, y, h, r2, d2, e2, r256, s256, pan, alpha, beta, tilt;
    gaze_t  g;
    x = tx; y = ty;
    h = neck_q - longint'(tz);
    r2 = x * x + y * y;
    d2 = r2 + h * h;
    e2 = eye_q * eye_q;
    r256 = floor_root(longint'(r2) << 16);
    g.close = (d2 < e2);
    g.clamped = 1'b0;
    pan = to_deg256(vec_angle(y * 256, x * 256), -PanLimit, PanLimit);
    alpha = vec_angle(r256, h * 256);
    if (g.close) beta = 0;
    else if (eye_q == 0) beta = 5898240;
    else begin
      s256 = floor_root((d2 - e2) << 16);
      beta = vec_angle(s256, eye_q * 256);
    end
    tilt = to_deg256(alpha + beta - Ang180, TiltLow, TiltHigh);
    if (tilt < floor_q) begin
      tilt = floor_q;
      g.clamped = 1'b1;
    end
    g.pan = pan[16:0];
    g.tilt = tilt[16:0];
    return g;
  endfunction

  // register write, only while idle; cfg_valid is dropped after each write
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NECK_HEIGHT: neck_q = longint'(val[19:0]);
      REG_EYE_OFFSET:  eye_q = longint'(val[15:0]);
      REG_TILT_FLOOR:  floor_q = longint'($signed(val[16:0]));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (gaze_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // one target item, sender idles at random unless in the busy stretch
  task automatic send_target(input logic signed [20:0] x, input logic signed [20:0] y,
                             input logic signed [20:0] z, input bit idle_ok);
    if (idle_ok) begin
      while ($urandom_range(99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    gaze_q.push_back(aim_angles(x, y, z));
  endtask

  function automatic logic signed [20:0] rand_coord(input int mode);
    case (mode)
      0: return 21'($signed($urandom_range(8000)) - 4000);
      1: return 21'($signed($urandom_range(80000)) - 40000);
      default: return 21'($urandom);
    endcase
  endfunction

  // receiver: stalls at random, checks each result item
  always @(posedge clk_i) begin
    gaze_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (gaze_q.size() == 0) begin
          report_mismatch("unexpected result item", 0, 0);
        end else begin
          want = gaze_q.pop_front();
          if ($signed(m_axis_tdata[16:0]) != want.pan)
            report_mismatch("pan_angle", $signed(m_axis_tdata[16:0]), want.pan);
          if ($signed(m_axis_tdata[33:17]) != want.tilt)
            report_mismatch("tilt_angle", $signed(m_axis_tdata[33:17]), want.tilt);
          if (m_axis_tuser[0] != want.clamped)
            report_mismatch("tilt_clamped", m_axis_tuser[0], want.clamped);
          if (m_axis_tuser[1] != want.close)
            report_mismatch("too_close", m_axis_tuser[1], want.close);
          if (m_axis_tdata[39:34] != '0)
            report_mismatch("tdata padding", m_axis_tdata[39:34], 0);
        end
      end
      m_axis_tready <= out_busy || ($urandom_range(99) >= 37);
    end
  end

  aim_row_t rows[$];

  initial begin
    aim_row_t row;
    gaze_t    want;
    int       mode;
    bit       idle_ok;
    err_cnt = 0;
    out_busy = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_NECK_HEIGHT;
    cfg_data = '0;
    neck_q = 28251;
    eye_q = 1184;
    floor_q = -12032;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; known rows have results read off by hand
    // at the neck: too close, tilt of -180 degrees raised to the floor
    want = '{pan: 17'sd0, tilt: -17'sd12032, clamped: 1'b1, close: 1'b1};
    rows.push_back('{x: 0, y: 0, z: 28251, known: 1, want: want});  // at the neck
    want = '{pan: 17'sd0, tilt: -17'sd12032, clamped: 1'b1, close: 1'b0};
    rows.push_back('{x: 0, y: 0, z: -1048576, known: 1, want: want}); // straight below
    rows.push_back('{x: 1048575, y: 0, z: 0, known: 0, want: want});
    rows.push_back('{x: -1048576, y: 0, z: 0, known: 0, want: want});
    rows.push_back('{x: -1048576, y: -1, z: 0, known: 0, want: want});
    rows.push_back('{x: 0, y: 1048575, z: 1048575, known: 0, want: want});
    rows.push_back('{x: 0, y: -1048576, z: 28251, known: 0, want: want});
    rows.push_back('{x: -1048576, y: -1048576, z: -1048576, known: 0, want: want});
    rows.push_back('{x: 1048575, y: 1048575, z: 1048575, known: 0, want: want});
    rows.push_back('{x: 100, y: 50, z: 28000, known: 0, want: want}); // nearer than eyes
    rows.push_back('{x: 1184, y: 0, z: 28251, known: 0, want: want});
    rows.push_back('{x: 0, y: 0, z: 28251 + 1184, known: 0, want: want});
    rows.push_back('{x: 0, y: 0, z: 28251 - 1184, known: 0, want: want});
    rows.push_back('{x: -5, y: 3, z: 27000, known: 0, want: want});
    rows.push_back('{x: 1, y: -1, z: 0, known: 0, want: want});
    rows.push_back('{x: 20000, y: -30000, z: 5000, known: 0, want: want});
    foreach (rows[i]) begin
      send_target(rows[i].x, rows[i].y, rows[i].z, 1'b1);
      if (rows[i].known && aim_angles(rows[i].x, rows[i].y, rows[i].z) != rows[i].want)
        report_mismatch("hand-typed expectation", i, 0);
    end
    s_axis_tvalid <= 1'b0;
    drain_results();

    // phases of register settings, extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_NECK_HEIGHT, 20'd0);
          write_reg(REG_EYE_OFFSET, 20'd1);
          write_reg(REG_TILT_FLOOR, 20'(-46080));
        end
        1: begin
          write_reg(REG_NECK_HEIGHT, 20'hFFFFF);
          write_reg(REG_EYE_OFFSET, 20'hFFFF);
          write_reg(REG_TILT_FLOOR, 20'd0);
        end
        2: begin
          write_reg(REG_EYE_OFFSET, 20'd0);            // eye offset zero
          write_reg(REG_TILT_FLOOR, 20'd5000);         // positive floor
          write_reg(REG_NONE, 20'd12345);              // ignored index
        end
        3: begin
          write_reg(REG_NECK_HEIGHT, 20'($urandom));
          write_reg(REG_EYE_OFFSET, 20'($urandom));
          write_reg(REG_TILT_FLOOR, 20'(-$signed(17'($urandom_range(46080)))));
        end
        4: begin
          write_reg(REG_NECK_HEIGHT, 20'd28251);
          write_reg(REG_EYE_OFFSET, 20'd1184);
          write_reg(REG_TILT_FLOOR, 20'(-12032));
        end
        default: begin
          write_reg(REG_NECK_HEIGHT, 20'($urandom_range(40000)));
          write_reg(REG_EYE_OFFSET, 20'($urandom_range(4000, 1)));
          write_reg(REG_TILT_FLOOR, 20'(-$signed(17'($urandom_range(46080)))));
        end
      endcase
      for (int n = 0; n < 325; n++) begin
        idle_ok = !(phase == 4 && n >= 100 && n < 250);
        out_busy = !idle_ok;
        mode = $urandom_range(2);
        if ($urandom_range(3) == 0)
          send_target(rand_coord(0), rand_coord(0), 21'(neck_q) + rand_coord(0), idle_ok);
        else
          send_target(rand_coord(mode), rand_coord(mode), rand_coord(mode), idle_ok);
      end
      out_busy = 1'b0;
      s_axis_tvalid <= 1'b0;
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ptga_pkg.sv
rtl/core/ptga_sqrt_cell.sv
rtl/core/ptga_cordic_cell.sv
rtl/core/pan_tilt_gaze_angles.sv
tb/pan_tilt_gaze_angles_tb.sv
